// ===== hdl/hbcd_pkg.sv =====
// Shared types and constants for the HTTP chunked body decoder.
package hbcd_pkg;

	localparam logic [7:0] CHAR_CR = 8'h0d;
	localparam logic [7:0] CHAR_LF = 8'h0a;
	localparam int unsigned SIZE_RADIX_BITS = 4;  // hex digit per size-line char

	typedef enum logic [1:0] {
		PH_SIZE = 2'd0,
		PH_DATA = 2'd1,
		PH_CRLF = 2'd2,
		PH_DONE = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		CFG_CHUNKED_MODE = 2'd0,
		CFG_LENGTH_KNOWN = 2'd1,
		CFG_BODY_LEN     = 2'd2
	} cfg_index_t;

	typedef enum logic {
		OP_BYTE  = 1'b0,
		OP_RESET = 1'b1
	} op_t;

	typedef struct packed {
		logic        payload_valid;
		logic [7:0]  payload_byte;
		logic        segment_last;
		logic        complete;
		logic [31:0] received_count;
		logic [1:0]  chunk_phase;
	} result_t;

	typedef struct packed {
		logic                       ok;
		logic [SIZE_RADIX_BITS-1:0] value;
	} hex_t;

	function automatic hex_t hex_digit(input logic [7:0] c);
		hex_t h;
		h.ok = 1'b1;
		h.value = '0;
		if (c >= 8'h30 && c <= 8'h39) begin
			h.value = 4'(c - 8'h30);
		end else if (c >= 8'h61 && c <= 8'h66) begin
			h.value = 4'(c - 8'h57);
		end else if (c >= 8'h41 && c <= 8'h46) begin
			h.value = 4'(c - 8'h37);
		end else begin
			h.ok = 1'b0;
		end
		return h;
	endfunction

endpackage

// ===== hdl/http_body_chunked_decoder_core.sv =====
// HTTP body decoder: chunked or plain body bytes in, payload bytes and status out.
// Each input transfer is registered in the input stage; its result is then registered in the result buffer.
// Throughput: one byte per cycle while the result buffer has room; in_stall holds the input otherwise.
// A two-entry result buffer absorbs output stalls; in_stall comes from registers only.
// Reset (arst_n low, asynchronous) clears decoder state, configuration registers and all valid flags.
module http_body_chunked_decoder_core
	import hbcd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,

	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_index,
	input  logic [30:0] cfg_data,

	input  logic        in_valid,
	output logic        in_stall,
	input  logic        op,
	input  logic [7:0]  data_byte,
	input  logic        segment_end,

	output logic        out_valid,
	input  logic        out_stall,
	output logic        payload_valid,
	output logic [7:0]  payload_byte,
	output logic        segment_last,
	output logic        complete,
	output logic [31:0] received_count,
	output logic [1:0]  chunk_phase
);

	// configuration
	logic        chunked_mode_q;
	logic        length_known_q;
	logic [30:0] body_len_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chunked_mode_q <= 1'b0;
			length_known_q <= 1'b0;
			body_len_q     <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index_t'(cfg_index))
				CFG_CHUNKED_MODE: chunked_mode_q <= cfg_data[0];
				CFG_LENGTH_KNOWN: length_known_q <= cfg_data[0];
				CFG_BODY_LEN:     body_len_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	// input register
	logic       valid_s1;
	logic       op_s1;
	logic [7:0] byte_s1;
	logic       seg_s1;
	logic       in_xfer;
	logic       adv;
	logic       skid_valid_q;

	assign adv      = valid_s1 && !skid_valid_q;
	assign in_stall = valid_s1 && skid_valid_q;
	assign in_xfer  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			op_s1   <= op;
			byte_s1 <= data_byte;
			seg_s1  <= segment_end;
		end
	end

	// decoder state
	phase_t      phase_q;
	logic [31:0] chunk_left_q;
	logic [31:0] byte_count_q;
	logic        finished_q;

	phase_t      phase_d;
	logic [31:0] chunk_left_d;
	logic [31:0] byte_count_d;
	logic        finished_d;
	logic        deliver;
	logic [31:0] count_inc;
	logic [31:0] clen_ext;
	hex_t        hx;
	result_t     res;

	assign clen_ext  = {1'b0, body_len_q};
	assign count_inc = (byte_count_q == '1) ? byte_count_q : byte_count_q + 32'd1;
	assign hx        = hex_digit(byte_s1);

	always_comb begin
		phase_d      = phase_q;
		chunk_left_d = chunk_left_q;
		byte_count_d = byte_count_q;
		finished_d   = finished_q;
		deliver      = 1'b0;
		if (op_t'(op_s1) == OP_RESET) begin
			phase_d      = PH_SIZE;
			chunk_left_d = '0;
			byte_count_d = '0;
			finished_d   = 1'b0;
		end else if (!finished_q) begin
			if (chunked_mode_q) begin
				unique case (phase_q)
					PH_SIZE: begin
						if (byte_s1 == CHAR_LF) begin
							if (chunk_left_q == '0) begin
								phase_d    = PH_DONE;
								finished_d = 1'b1;
							end else begin
								phase_d = PH_DATA;
							end
						end else if (byte_s1 != CHAR_CR && hx.ok) begin
							chunk_left_d = {chunk_left_q[31-SIZE_RADIX_BITS:0], hx.value};
						end
					end
					PH_DATA: begin
						deliver      = 1'b1;
						byte_count_d = count_inc;
						if (chunk_left_q != '0) begin
							chunk_left_d = chunk_left_q - 32'd1;
						end
						// remaining count reaches zero: move on to the trailing CRLF
						if (chunk_left_q <= 32'd1) begin
							phase_d = PH_CRLF;
						end
					end
					PH_CRLF: begin
						if (byte_s1 == CHAR_LF) begin
							phase_d      = PH_SIZE;
							chunk_left_d = '0;
						end
					end
					default: finished_d = 1'b1;
				endcase
			end else begin
				if (length_known_q && byte_count_q >= clen_ext) begin
					finished_d = 1'b1;
				end else begin
					deliver      = 1'b1;
					byte_count_d = count_inc;
					if (length_known_q && count_inc >= clen_ext) begin
						finished_d = 1'b1;
					end
				end
			end
		end
		res.payload_valid  = deliver;
		res.payload_byte   = deliver ? byte_s1 : 8'h00;
		res.segment_last   = seg_s1;
		res.complete       = finished_d;
		res.received_count = byte_count_d;
		res.chunk_phase    = phase_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_SIZE;
			chunk_left_q <= '0;
			byte_count_q <= '0;
			finished_q   <= 1'b0;
		end else if (adv) begin
			phase_q      <= phase_d;
			chunk_left_q <= chunk_left_d;
			byte_count_q <= byte_count_d;
			finished_q   <= finished_d;
		end
	end

	// two-entry result buffer: head drives the ports, skid catches a stalled transfer
	logic    head_valid_q;
	result_t head_q;
	result_t skid_q;
	logic    pop;

	assign pop = head_valid_q && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (skid_valid_q) begin
				if (pop) begin
					skid_valid_q <= 1'b0;
				end
			end else if (head_valid_q) begin
				if (!pop && adv) begin
					skid_valid_q <= 1'b1;
				end else if (pop && !adv) begin
					head_valid_q <= 1'b0;
				end
			end else if (adv) begin
				head_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) begin
				head_q <= skid_q;
			end
		end else if (head_valid_q) begin
			if (adv && pop) begin
				head_q <= res;
			end else if (adv) begin
				skid_q <= res;
			end
		end else if (adv) begin
			head_q <= res;
		end
	end

	assign out_valid      = head_valid_q;
	assign payload_valid  = head_q.payload_valid;
	assign payload_byte   = head_q.payload_byte;
	assign segment_last   = head_q.segment_last;
	assign complete       = head_q.complete;
	assign received_count = head_q.received_count;
	assign chunk_phase    = head_q.chunk_phase;

endmodule

// ===== bench/tb_http_body_chunked_decoder_core.sv =====
// Self-checking testbench for the HTTP chunked/plain body decoder core.
module tb_http_body_chunked_decoder_core;
	import hbcd_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	typedef enum int unsigned {IDLE_NONE, IDLE_LIGHT, IDLE_FULL} idle_mode_t;

	// Tracks decoder state on accepted transfers and holds the results still due.
	class body_scoreboard;
		phase_t      phase;
		logic [31:0] chunk_left;
		logic [31:0] byte_count;
		logic        finished;
		logic        chunked_mode;
		logic        length_known;
		logic [30:0] body_len;
		result_t     due_results[$];
		int unsigned mismatches;
		int unsigned checked;
		int unsigned delivered;
		int unsigned completed;

		function new();
			phase = PH_SIZE;
			chunk_left = '0;
			byte_count = '0;
			finished = 1'b0;
			chunked_mode = 1'b0;
			length_known = 1'b0;
			body_len = '0;
		endfunction

		function void set_reg(cfg_index_t idx, logic [30:0] v);
			case (idx)
				CFG_CHUNKED_MODE: chunked_mode = v[0];
				CFG_LENGTH_KNOWN: length_known = v[0];
				CFG_BODY_LEN:     body_len = v;
				default: ;
			endcase
		endfunction

		// Returns 1 unless the byte arrives after completion and is dropped.
		function bit decode_byte(op_t kind, logic [7:0] c, logic seg);
			result_t r;
			logic    deliver;
			logic    was_done;
			logic    hex_ok;
			logic [3:0] nib;
			was_done = finished;
			deliver = 1'b0;
			if (kind == OP_RESET) begin
				phase = PH_SIZE;
				chunk_left = '0;
				byte_count = '0;
				finished = 1'b0;
			end else if (!finished) begin
				if (chunked_mode) begin
					case (phase)
						PH_SIZE: begin
							hex_ok = 1'b1;
							nib = '0;
							if (c >= "0" && c <= "9") nib = 4'(c - "0");
							else if (c >= "a" && c <= "f") nib = 4'(c - "a" + 8'd10);
							else if (c >= "A" && c <= "F") nib = 4'(c - "A" + 8'd10);
							else hex_ok = 1'b0;
							if (c == CHAR_LF) begin
								if (chunk_left == 0) begin
									phase = PH_DONE;
									finished = 1'b1;
								end else begin
									phase = PH_DATA;
								end
							end else if (hex_ok) begin
								// size keeps only its low 32 bits
								chunk_left = {chunk_left[27:0], nib};
							end
						end
						PH_DATA: begin
							deliver = 1'b1;
							if (byte_count != '1) byte_count++;
							if (chunk_left != 0) chunk_left--;
							if (chunk_left == 0) phase = PH_CRLF;
						end
						PH_CRLF: begin
							if (c == CHAR_LF) begin
								phase = PH_SIZE;
								chunk_left = '0;
							end
						end
						default: finished = 1'b1;
					endcase
				end else begin
					if (length_known && byte_count >= {1'b0, body_len}) begin
						finished = 1'b1;
					end else begin
						deliver = 1'b1;
						if (byte_count != '1) byte_count++;
						if (length_known && byte_count >= {1'b0, body_len})
							finished = 1'b1;
					end
				end
			end
			if (deliver) delivered++;
			if (!was_done && finished) completed++;
			r.payload_valid = deliver;
			r.payload_byte = deliver ? c : 8'h00;
			r.segment_last = seg;
			r.complete = finished;
			r.received_count = byte_count;
			r.chunk_phase = phase;
			due_results.push_back(r);
			return kind == OP_RESET || !was_done;
		endfunction

		task report(string what);
			mismatches++;
			$display("MISMATCH @%0t: %s", $time, what);
		endtask

		task compare_field(string name, logic [31:0] got, logic [31:0] want);
			if (got !== want)
				report($sformatf("result %0d %s: got %0h, want %0h", checked, name, got, want));
		endtask

		task check_result(result_t got);
			result_t want;
			if (due_results.size() == 0) begin
				report($sformatf("result %h with nothing pending", got));
				return;
			end
			want = due_results.pop_front();
			checked++;
			compare_field("payload_valid", 32'(got.payload_valid), 32'(want.payload_valid));
			compare_field("payload_byte", 32'(got.payload_byte), 32'(want.payload_byte));
			compare_field("segment_last", 32'(got.segment_last), 32'(want.segment_last));
			compare_field("complete", 32'(got.complete), 32'(want.complete));
			compare_field("received_count", got.received_count, want.received_count);
			compare_field("chunk_phase", 32'(got.chunk_phase), 32'(want.chunk_phase));
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [30:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        op = 1'b0;
	logic [7:0]  data_byte = '0;
	logic        segment_end = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        payload_valid;
	logic [7:0]  payload_byte;
	logic        segment_last;
	logic        complete;
	logic [31:0] received_count;
	logic [1:0]  chunk_phase;

	body_scoreboard board = new();
	idle_mode_t  src_mode = IDLE_NONE;
	idle_mode_t  sink_mode = IDLE_NONE;
	int unsigned transfers = 0;
	int unsigned live_items = 0;
	int unsigned phase_no = 0;

	http_body_chunked_decoder_core DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.op             (op),
		.data_byte      (data_byte),
		.segment_end    (segment_end),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.payload_valid  (payload_valid),
		.payload_byte   (payload_byte),
		.segment_last   (segment_last),
		.complete       (complete),
		.received_count (received_count),
		.chunk_phase    (chunk_phase)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic int unsigned draw_wait(idle_mode_t mode);
		case (mode)
			IDLE_NONE:  return 0;
			IDLE_LIGHT: return $urandom_range(0, 2);
			default:    return $urandom_range(0, 16);
		endcase
	endfunction

	task automatic send_item(op_t kind, logic [7:0] c);
		int unsigned gap;
		gap = draw_wait(src_mode);
		@(negedge clk);
		if (gap != 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid = 1'b1;
		op = kind;
		data_byte = c;
		segment_end = ($urandom_range(0, 3) == 0);
		do @(posedge clk); while (in_stall);
		transfers++;
		if (board.decode_byte(kind, c, segment_end)) live_items++;
	endtask

	task automatic send_text(string s);
		for (int k = 0; k < s.len(); k++) send_item(OP_BYTE, s[k]);
	endtask

	task automatic send_crlf();
		send_item(OP_BYTE, CHAR_CR);
		send_item(OP_BYTE, CHAR_LF);
	endtask

	task automatic write_reg(cfg_index_t idx, logic [30:0] v);
		@(negedge clk);
		cfg_wr_en = 1'b1;
		cfg_index = idx;
		cfg_data = v;
		@(negedge clk);
		cfg_wr_en = 1'b0;
		board.set_reg(idx, v);
	endtask

	// Hold off the sender until every pending result has been seen.
	task automatic drain();
		@(negedge clk);
		in_valid = 1'b0;
		while (board.due_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Hex size with random letter case, optional leading zero and extension.
	task automatic send_size_line(int unsigned v);
		int unsigned n;
		logic [3:0]  nib;
		logic [7:0]  c;
		n = 1;
		while (n < 8 && (v >> (4 * n)) != 0) n++;
		repeat ($urandom_range(0, 1)) send_item(OP_BYTE, "0");
		for (int k = n; k > 0; k--) begin
			nib = 4'(v >> (4 * (k - 1)));
			if (nib < 10) c = "0" + 8'(nib);
			else c = ($urandom_range(0, 1) ? "a" : "A") + 8'(nib) - 8'd10;
			send_item(OP_BYTE, c);
		end
		if ($urandom_range(0, 3) == 0) send_text(";q=z");
		if ($urandom_range(0, 7) != 0) send_item(OP_BYTE, CHAR_CR);
		send_item(OP_BYTE, CHAR_LF);
	endtask

	task automatic send_chunked_body();
		int unsigned chunks;
		int unsigned size;
		int unsigned pick;
		bit          broken;
		logic [7:0]  c;
		chunks = $urandom_range(0, 4);
		broken = ($urandom_range(0, 9) == 0);
		if ($urandom_range(0, 3) != 0) send_item(OP_RESET, 8'($urandom));
		for (int k = 0; k < chunks; k++) begin
			pick = $urandom_range(0, 19);
			if (pick == 0) size = $urandom_range(100, 300);
			else if (pick < 4) size = $urandom_range(16, 80);
			else size = $urandom_range(1, 12);
			send_size_line(size);
			// truncated body: stop inside the last chunk's data
			if (broken && k == chunks - 1) begin
				repeat (size / 2) send_item(OP_BYTE, 8'($urandom));
				return;
			end
			repeat (size) send_item(OP_BYTE, 8'($urandom));
			case ($urandom_range(0, 7))
				0: begin
					repeat ($urandom_range(1, 3)) begin
						c = 8'($urandom);
						if (c == CHAR_LF) c = 8'h20;
						send_item(OP_BYTE, c);
					end
					send_crlf();
				end
				1: send_item(OP_BYTE, CHAR_LF);
				default: send_crlf();
			endcase
		end
		send_size_line(0);
		repeat ($urandom_range(0, 2)) send_item(OP_BYTE, 8'($urandom));
	endtask

	task automatic send_plain_body();
		int unsigned n;
		if ($urandom_range(0, 3) != 0) send_item(OP_RESET, 8'($urandom));
		if (board.length_known)
			n = (board.body_len > 60) ? $urandom_range(10, 60)
				: board.body_len + $urandom_range(0, 3);
		else
			n = $urandom_range(1, 40);
		repeat (n) send_item(OP_BYTE, 8'($urandom));
	endtask

	task automatic send_noise_body();
		repeat ($urandom_range(10, 40))
			send_item(($urandom_range(0, 15) == 0) ? OP_RESET : OP_BYTE, 8'($urandom));
	endtask

	initial begin : stimulus
		int unsigned pick;
		logic [30:0] len;
		logic        mode_bit;
		logic        known;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: extension and CR on the size line, LF inside data, zero chunk,
		// byte after completion, new response, oversized size line
		write_reg(CFG_CHUNKED_MODE, 31'd1);
		write_reg(CFG_LENGTH_KNOWN, 31'd1);
		write_reg(CFG_BODY_LEN, 31'h7fff_ffff);
		send_text("3;x");
		send_crlf();
		send_item(OP_BYTE, 8'h00);
		send_item(OP_BYTE, 8'hff);
		send_item(OP_BYTE, CHAR_LF);
		send_crlf();
		send_text("0");
		send_crlf();
		send_item(OP_BYTE, "A");
		send_item(OP_RESET, 8'hff);
		send_text("1aF2345678");
		send_item(OP_RESET, 8'h00);
		// plain body whose known length is already reached
		drain();
		write_reg(CFG_CHUNKED_MODE, 31'd0);
		write_reg(CFG_BODY_LEN, 31'd0);
		send_item(OP_RESET, 8'h5a);
		send_item(OP_BYTE, 8'h55);

		while (transfers < 1800) begin
			drain();
			mode_bit = (phase_no < 3) ? 1'b0 : 1'($urandom_range(0, 1));
			known = (phase_no < 3) ? 1'b1 : 1'($urandom_range(0, 1));
			pick = (phase_no < 3) ? phase_no : $urandom_range(0, 5);
			case (pick)
				0: len = 31'h7fff_ffff;
				1: len = 31'd1;
				2: len = 31'd0;
				3: len = 31'($urandom);
				default: len = 31'($urandom_range(2, 48));
			endcase
			// registers not rewritten keep their value, so the body state rolls on
			if (phase_no < 3 || $urandom_range(0, 3) != 0) write_reg(CFG_CHUNKED_MODE, 31'(mode_bit));
			if (phase_no < 3 || $urandom_range(0, 3) != 0) write_reg(CFG_LENGTH_KNOWN, 31'(known));
			if (phase_no < 3 || $urandom_range(0, 3) != 0) write_reg(CFG_BODY_LEN, len);
			repeat (4) begin
				src_mode = idle_mode_t'($urandom_range(0, 2));
				if ($urandom_range(0, 7) == 0) send_noise_body();
				else if (board.chunked_mode) send_chunked_body();
				else send_plain_body();
			end
			phase_no++;
		end

		@(negedge clk);
		in_valid = 1'b0;
		while (board.due_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		$display("Sent %0d transfers (%0d acted on) over %0d register settings.",
			transfers, live_items, phase_no + 2);
		$display("Checked %0d results: %0d payload bytes, %0d bodies completed, %0d mismatches.",
			board.checked, board.delivered, board.completed, board.mismatches);
		if (board.mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin : result_sink
		result_t     got;
		int unsigned n;
		forever begin
			if ($urandom_range(0, 63) == 0) sink_mode = idle_mode_t'($urandom_range(0, 2));
			n = draw_wait(sink_mode);
			repeat (n) begin
				@(negedge clk);
				out_stall = 1'b1;
			end
			@(negedge clk);
			out_stall = 1'b0;
			do @(posedge clk); while (!out_valid);
			got.payload_valid = payload_valid;
			got.payload_byte = payload_byte;
			got.segment_last = segment_last;
			got.complete = complete;
			got.received_count = received_count;
			got.chunk_phase = chunk_phase;
			board.check_result(got);
		end
	end

	initial begin : watchdog
		#20_000_000;
		$display("Watchdog expired with %0d results outstanding.", board.due_results.size());
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ===== http_body_chunked_decoder_core.f =====
hdl/hbcd_pkg.sv
hdl/http_body_chunked_decoder_core.sv
bench/tb_http_body_chunked_decoder_core.sv
